// ===== src/wbpt_pkg.sv =====
// Shared types and codes for the work/break phase timer.
`default_nettype none
package wbpt_pkg;

    // Phase codes
    localparam logic [1:0] PH_WORK  = 2'd0;
    localparam logic [1:0] PH_SHORT = 2'd1;
    localparam logic [1:0] PH_LONG  = 2'd2;

    // Event codes
    localparam logic [1:0] FN_TICK    = 2'd0;
    localparam logic [1:0] FN_ORIENT  = 2'd1;
    localparam logic [1:0] FN_SKIP    = 2'd2;
    localparam logic [1:0] FN_RESTART = 2'd3;

    // Face codes that act
    localparam logic [2:0] FACE_FRONT = 3'd0;
    localparam logic [2:0] FACE_TOP   = 3'd1;

    // Buzzer commands
    localparam logic [1:0] BUZ_NONE  = 2'd0;
    localparam logic [1:0] BUZ_OFF   = 2'd1;
    localparam logic [1:0] BUZ_ALARM = 2'd2;

    // Register indexes
    localparam logic [1:0] CFG_WORK_SECONDS  = 2'd0;
    localparam logic [1:0] CFG_SHORT_SECONDS = 2'd1;
    localparam logic [1:0] CFG_LONG_SECONDS  = 2'd2;
    localparam logic [1:0] CFG_WORKS_PER_SET = 2'd3;

    localparam logic [15:0] RESET_SECONDS = 16'd60;
    localparam logic [3:0]  RESET_WORKS   = 4'd4;
    localparam logic [3:0]  WORKS_MAX     = 4'd15;

    typedef struct packed {
        logic [15:0] remaining;
        logic [1:0]  phase;
        logic [3:0]  works;
        logic        running;
        logic        arrow;
    } state_t;

    typedef struct packed {
        logic [15:0] work_seconds;
        logic [15:0] short_seconds;
        logic [15:0] long_seconds;
        logic [3:0]  works_per_set;
    } cfg_t;

    typedef struct packed {
        logic [1:0] buzzer;
        logic       refresh;
    } evt_out_t;

endpackage
`default_nettype wire

// ===== src/wbpt_step.sv =====
// Next-state and event-output logic of the phase timer for one event.
`default_nettype none
module wbpt_step
    import wbpt_pkg::*;
(
    input  state_t     cur,
    input  cfg_t       cfg,
    input  logic [1:0] func,
    input  logic [2:0] face,
    output state_t     nxt,
    output evt_out_t   evt
);

    // Move to the following phase, load its length and pause.
    function automatic state_t advance(input state_t s, input cfg_t c);
        state_t     r;
        logic [3:0] cnt;
        r   = s;
        cnt = (s.works < WORKS_MAX) ? s.works + 4'd1 : WORKS_MAX;
        case (s.phase)
            PH_WORK: begin
                r.works = cnt;
                if (cnt >= c.works_per_set) begin
                    r.phase     = PH_LONG;
                    r.remaining = c.long_seconds;
                end else begin
                    r.phase     = PH_SHORT;
                    r.remaining = c.short_seconds;
                end
            end
            PH_SHORT: begin
                r.phase     = PH_WORK;
                r.remaining = c.work_seconds;
            end
            PH_LONG: begin
                r.works     = 4'd0;
                r.phase     = PH_WORK;
                r.remaining = c.work_seconds;
            end
            default: ;
        endcase
        r.running = 1'b0;
        return r;
    endfunction

    state_t dec;
    logic   toggle_face;

    assign toggle_face = (face == FACE_FRONT) || (face == FACE_TOP);

    always_comb begin
        dec           = cur;
        dec.remaining = (cur.remaining != 16'd0) ? cur.remaining - 16'd1 : 16'd0;
    end

    always_comb begin
        nxt         = cur;
        evt.buzzer  = BUZ_NONE;
        evt.refresh = 1'b0;
        unique case (func)
            FN_TICK: begin
                if (cur.running) begin
                    evt.refresh = 1'b1;
                    if (dec.remaining == 16'd0) begin
                        nxt        = advance(dec, cfg);
                        evt.buzzer = BUZ_ALARM;
                    end else begin
                        nxt = dec;
                    end
                end
            end
            FN_ORIENT: begin
                if (face == FACE_FRONT) nxt.arrow = 1'b0;
                if (face == FACE_TOP)   nxt.arrow = 1'b1;
                if (toggle_face) begin
                    evt.refresh = 1'b1;
                    nxt.running = ~cur.running;
                    if (!cur.running) evt.buzzer = BUZ_OFF;
                end
            end
            FN_SKIP: begin
                nxt         = advance(cur, cfg);
                evt.buzzer  = BUZ_OFF;
                evt.refresh = 1'b1;
            end
            default: begin
                // restart: back to a paused work phase, arrow kept
                nxt.remaining = cfg.work_seconds;
                nxt.phase     = PH_WORK;
                nxt.works     = 4'd0;
                nxt.running   = 1'b0;
                evt.buzzer    = BUZ_OFF;
                evt.refresh   = 1'b1;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== src/work_break_phase_timer_top.sv =====
// Top level of the work/break phase timer: state, registers and result stage.
//
// Work/break phase timer. Each event transfer on the s_ channel (tick,
// orientation change, skip, restart) produces exactly one result transfer on
// the m_ channel, carrying the remaining seconds, run flag, phase, completed
// work count, arrow direction, buzzer command and refresh flag after that
// event. One event is taken per clock while ready; the result appears in the
// cycle after acceptance, from the output register. s_ready stays high while
// the output register is empty or being drained, so a stalled consumer holds
// back the input only once a result is waiting. Register writes (cfg_we,
// cfg_index, cfg_data) take effect at the next edge and only change the
// phase lengths and set size, never the running state; a new length is used
// the next time that phase is entered. After reset the timer is paused in
// the work phase with 60 s left, lengths 60/60/60 s and four works per set.
`default_nettype none
module work_break_phase_timer_top
    import wbpt_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    // event channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_func,
    input  wire logic [2:0]  s_face,
    // result channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_seconds_left,
    output logic             m_is_running,
    output logic [1:0]       m_phase_now,
    output logic [3:0]       m_works_done,
    output logic             m_arrow_down,
    output logic [1:0]       m_buzzer_cmd,
    output logic             m_display_refresh
);

    state_t   state_reg;
    state_t   state_next;
    cfg_t     cfg_reg;
    evt_out_t evt_next;
    evt_out_t evt_reg;
    state_t   res_reg;
    logic     m_valid_reg;
    logic     accept;

    // Output register free or emptying this cycle
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    wbpt_step u_step (
        .cur  (state_reg),
        .cfg  (cfg_reg),
        .func (s_func),
        .face (s_face),
        .nxt  (state_next),
        .evt  (evt_next)
    );

    // Control state and registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.remaining   <= RESET_SECONDS;
            state_reg.phase       <= PH_WORK;
            state_reg.works       <= 4'd0;
            state_reg.running     <= 1'b0;
            state_reg.arrow       <= 1'b0;
            cfg_reg.work_seconds  <= RESET_SECONDS;
            cfg_reg.short_seconds <= RESET_SECONDS;
            cfg_reg.long_seconds  <= RESET_SECONDS;
            cfg_reg.works_per_set <= RESET_WORKS;
            m_valid_reg           <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_WORK_SECONDS:  cfg_reg.work_seconds  <= cfg_data;
                    CFG_SHORT_SECONDS: cfg_reg.short_seconds <= cfg_data;
                    CFG_LONG_SECONDS:  cfg_reg.long_seconds  <= cfg_data;
                    default:           cfg_reg.works_per_set <= cfg_data[3:0];
                endcase
            end
            if (accept) begin
                state_reg   <= state_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload, loaded with each accepted event
    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= state_next;
            evt_reg <= evt_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_seconds_left    = res_reg.remaining;
    assign m_is_running      = res_reg.running;
    assign m_phase_now       = res_reg.phase;
    assign m_works_done      = res_reg.works;
    assign m_arrow_down      = res_reg.arrow;
    assign m_buzzer_cmd      = evt_reg.buzzer;
    assign m_display_refresh = evt_reg.refresh;

endmodule
`default_nettype wire

// ===== src/wbpt_checker.sv =====
// Port-level checks for the phase timer, bound to the top level.
`default_nettype none
module wbpt_checker
    import wbpt_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [15:0] m_seconds_left,
    input wire logic        m_is_running,
    input wire logic [1:0]  m_phase_now,
    input wire logic [1:0]  m_buzzer_cmd,
    input wire logic        m_display_refresh
);

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_seconds_left)
            && $stable(m_buzzer_cmd))
        else $error("result changed while stalled");

    // Input never blocked while output register is empty
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("s_ready low with empty output");

    // Each accepted event gives a result next cycle
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted event gave no result");

    // Alarm always leaves the timer paused
    a_alarm: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_buzzer_cmd == BUZ_ALARM |-> !m_is_running && m_display_refresh)
        else $error("alarm without pause");

    // Silent events never drive the buzzer
    a_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_display_refresh |-> m_buzzer_cmd == BUZ_NONE
            && m_phase_now != 2'd3)
        else $error("buzzer command on a non-refreshing event");

endmodule

bind work_break_phase_timer_top wbpt_checker u_wbpt_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_seconds_left    (m_seconds_left),
    .m_is_running      (m_is_running),
    .m_phase_now       (m_phase_now),
    .m_buzzer_cmd      (m_buzzer_cmd),
    .m_display_refresh (m_display_refresh)
);
`default_nettype wire

// ===== tb/sv/work_break_phase_timer_top_tb.sv =====
// Testbench for the work/break phase timer: directed and random events, scoreboard checking.
`timescale 1ns / 100ps

import wbpt_pkg::*;

// One result transfer as the block presents it.
typedef struct packed {
    logic [15:0] secs;
    logic        running;
    logic [1:0]  phase;
    logic [3:0]  works;
    logic        arrow;
    logic [1:0]  buzzer;
    logic        refresh;
} timer_result_t;

// Scoreboard: keeps its own copy of the timer and of the lengths, works out
// the result of every accepted event and checks results in order.
class phase_timer_sb;
    logic [15:0]   work_len;
    logic [15:0]   short_len;
    logic [15:0]   long_len;
    logic [3:0]    set_size;
    logic [15:0]   secs_left;
    logic [1:0]    phase;
    logic [3:0]    works;
    logic          running;
    logic          arrow;
    bit            last_refresh;
    timer_result_t expected_q[$];
    int unsigned   error_count;

    function new();
        work_len     = RESET_SECONDS;
        short_len    = RESET_SECONDS;
        long_len     = RESET_SECONDS;
        set_size     = RESET_WORKS;
        secs_left    = RESET_SECONDS;
        phase        = PH_WORK;
        works        = 4'd0;
        running      = 1'b0;
        arrow        = 1'b0;
        last_refresh = 1'b0;
        error_count  = 0;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void set_reg(input logic [1:0] idx, input logic [15:0] val);
        case (idx)
            CFG_WORK_SECONDS:  work_len  = val;
            CFG_SHORT_SECONDS: short_len = val;
            CFG_LONG_SECONDS:  long_len  = val;
            CFG_WORKS_PER_SET: set_size  = val[3:0];
            default: ;
        endcase
    endfunction

    // Move on to the next phase, load its length and pause.
    function void enter_next_phase();
        case (phase)
            PH_WORK: begin
                if (works < WORKS_MAX)
                    works = works + 4'd1;
                if (works >= set_size) begin
                    phase     = PH_LONG;
                    secs_left = long_len;
                end else begin
                    phase     = PH_SHORT;
                    secs_left = short_len;
                end
            end
            PH_SHORT: begin
                phase     = PH_WORK;
                secs_left = work_len;
            end
            PH_LONG: begin
                works     = 4'd0;
                phase     = PH_WORK;
                secs_left = work_len;
            end
            default: ;
        endcase
        running = 1'b0;
    endfunction

    // Accepted event: update the copy and queue the result it must give.
    function void note_event(input logic [1:0] f, input logic [2:0] fc);
        timer_result_t r;
        logic [1:0]    buz;
        logic          refresh;
        buz     = BUZ_NONE;
        refresh = 1'b0;
        case (f)
            FN_TICK: begin
                if (running) begin
                    if (secs_left != 16'd0)
                        secs_left = secs_left - 16'd1;
                    if (secs_left == 16'd0) begin
                        buz = BUZ_ALARM;
                        enter_next_phase();
                    end
                    refresh = 1'b1;
                end
            end
            FN_ORIENT: begin
                if (fc == FACE_FRONT)
                    arrow = 1'b0;
                else if (fc == FACE_TOP)
                    arrow = 1'b1;
                if (fc == FACE_FRONT || fc == FACE_TOP) begin
                    if (running) begin
                        running = 1'b0;
                    end else begin
                        running = 1'b1;
                        buz     = BUZ_OFF;
                    end
                    refresh = 1'b1;
                end
            end
            FN_SKIP: begin
                buz = BUZ_OFF;
                enter_next_phase();
                refresh = 1'b1;
            end
            default: begin
                secs_left = work_len;
                phase     = PH_WORK;
                works     = 4'd0;
                running   = 1'b0;
                buz       = BUZ_OFF;
                refresh   = 1'b1;
            end
        endcase
        r.secs    = secs_left;
        r.running = running;
        r.phase   = phase;
        r.works   = works;
        r.arrow   = arrow;
        r.buzzer  = buz;
        r.refresh = refresh;
        expected_q.push_back(r);
        last_refresh = refresh;
    endfunction

    task report(input string msg);
        $display("MISMATCH: %s", msg);
        error_count++;
    endtask

    task check_field(input string name, input logic [15:0] got, input logic [15:0] want);
        if (got !== want)
            report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check_result(input timer_result_t got);
        timer_result_t want;
        if (expected_q.size() == 0) begin
            report("result transfer with nothing expected");
        end else begin
            want = expected_q.pop_front();
            check_field("seconds_left",    got.secs,         want.secs);
            check_field("is_running",      16'(got.running), 16'(want.running));
            check_field("phase_now",       16'(got.phase),   16'(want.phase));
            check_field("works_done",      16'(got.works),   16'(want.works));
            check_field("arrow_down",      16'(got.arrow),   16'(want.arrow));
            check_field("buzzer_cmd",      16'(got.buzzer),  16'(want.buzzer));
            check_field("display_refresh", 16'(got.refresh), 16'(want.refresh));
        end
    endtask
endclass

module work_break_phase_timer_top_tb;

    // Generous: room for all the events, plus drains and the long receiver
    // hold-off, taken several times over.
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 300;

    logic        aclk              = 1'b0;
    logic        aresetn           = 1'b0;
    logic        cfg_we            = 1'b0;
    logic [1:0]  cfg_index         = CFG_WORK_SECONDS;
    logic [15:0] cfg_data          = 16'd0;
    logic        s_valid           = 1'b0;
    logic        s_ready;
    logic [1:0]  s_func            = FN_TICK;
    logic [2:0]  s_face            = FACE_FRONT;
    logic        m_valid;
    logic        m_ready           = 1'b0;
    logic [15:0] m_seconds_left;
    logic        m_is_running;
    logic [1:0]  m_phase_now;
    logic [3:0]  m_works_done;
    logic        m_arrow_down;
    logic [1:0]  m_buzzer_cmd;
    logic        m_display_refresh;

    // Shared between the sender and the receiver process.
    bit quiet         = 1'b0;   // no idling on either side
    bit long_hold_req = 1'b0;   // receiver to take its long hold-off

    int unsigned   cycle_count = 0;
    phase_timer_sb sb = new();

    work_break_phase_timer_top u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_func            (s_func),
        .s_face            (s_face),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_seconds_left    (m_seconds_left),
        .m_is_running      (m_is_running),
        .m_phase_now       (m_phase_now),
        .m_works_done      (m_works_done),
        .m_arrow_down      (m_arrow_down),
        .m_buzzer_cmd      (m_buzzer_cmd),
        .m_display_refresh (m_display_refresh)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Watchdog: a stuck handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result monitor. At the edge the outputs still hold their pre-edge values,
    // i.e. the ones the handshake was decided on.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result('{secs:    m_seconds_left,
                              running: m_is_running,
                              phase:   m_phase_now,
                              works:   m_works_done,
                              arrow:   m_arrow_down,
                              buzzer:  m_buzzer_cmd,
                              refresh: m_display_refresh});
    end

    // Receiver: ready in random stretches, random stalls, and a long
    // hold-off on request so the output stage fills and s_ready drops.
    initial begin
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    // Offer one event and hold it until the transfer happens. Valid is left
    // high; whoever drives next decides whether it drops.
    task automatic send_event(input logic [1:0] f, input logic [2:0] fc);
        s_valid <= 1'b1;
        s_func  <= f;
        s_face  <= fc;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_event(f, fc);
    endtask

    task automatic idle_sender(input int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    // Stop offering and wait until every expected result has been seen,
    // then let the output stage settle.
    task automatic wait_results_done();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        sb.set_reg(idx, val);
    endtask

    // All four registers, back to back; only ever called with the block idle.
    task automatic program_timer(input logic [15:0] w, input logic [15:0] s,
                                 input logic [15:0] l, input logic [15:0] n);
        write_reg(CFG_WORK_SECONDS,  w);
        write_reg(CFG_SHORT_SECONDS, s);
        write_reg(CFG_LONG_SECONDS,  l);
        write_reg(CFG_WORKS_PER_SET, n);
        cfg_we <= 1'b0;
    endtask

    // Mostly short lengths so alarms come often, now and then the extremes.
    function automatic logic [15:0] pick_len();
        case ($urandom_range(0, 9))
            0:       return 16'hFFFF;
            1:       return 16'($urandom);
            2:       return 16'd0;
            default: return 16'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic logic [15:0] pick_set_size();
        return {12'($urandom), 4'($urandom_range(1, 15))};
    endfunction

    // Random events until 'target' of them have done something visible;
    // paused ticks and other faces ride along as noise.
    task automatic run_events(input int target);
        int         done;
        int         r;
        logic [1:0] f;
        logic [2:0] fc;
        done = 0;
        while (done < target) begin
            r = $urandom_range(0, 99);
            if (r < 55)
                f = FN_TICK;
            else if (r < 80)
                f = FN_ORIENT;
            else if (r < 93)
                f = FN_SKIP;
            else
                f = FN_RESTART;
            // front/top dominate so the timer actually runs
            if ($urandom_range(0, 3) != 0)
                fc = 3'($urandom_range(0, 1));
            else
                fc = 3'($urandom_range(0, 5));
            if (!quiet && $urandom_range(0, 4) == 0)
                idle_sender($urandom_range(1, 17));
            send_event(f, fc);
            if (sb.last_refresh)
                done++;
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset lengths: paused tick, faces that do nothing, run/pause via
        // both faces, skip while running and while paused, restart.
        send_event(FN_TICK, FACE_FRONT);
        send_event(FN_ORIENT, 3'd2);
        send_event(FN_ORIENT, 3'd5);
        send_event(FN_ORIENT, FACE_FRONT);
        send_event(FN_TICK, 3'd7 & 3'd4);
        send_event(FN_ORIENT, FACE_TOP);
        send_event(FN_TICK, FACE_TOP);
        send_event(FN_ORIENT, FACE_TOP);
        send_event(FN_SKIP, FACE_FRONT);
        send_event(FN_SKIP, 3'd3);
        send_event(FN_RESTART, 3'd5);
        wait_results_done();

        // One-second work, zero short, maximum long, set of one.
        program_timer(16'd1, 16'd0, 16'hFFFF, 16'd1);
        send_event(FN_ORIENT, FACE_FRONT);
        send_event(FN_TICK, FACE_FRONT);
        send_event(FN_ORIENT, FACE_FRONT);
        send_event(FN_TICK, FACE_FRONT);
        send_event(FN_SKIP, FACE_TOP);
        send_event(FN_RESTART, FACE_FRONT);
        wait_results_done();

        // Zero work and long lengths and a set size of zero: a tick at zero stays at zero
        // and still sounds the alarm; every work phase leads to a long break.
        program_timer(16'd0, 16'd2, 16'd0, 16'd0);
        send_event(FN_ORIENT, FACE_TOP);
        send_event(FN_TICK, FACE_TOP);
        send_event(FN_ORIENT, FACE_FRONT);
        send_event(FN_TICK, FACE_FRONT);
        send_event(FN_SKIP, FACE_FRONT);
        wait_results_done();

        // Largest set size with short lengths so the count climbs to 15.
        program_timer(16'd3, 16'd2, 16'd4, 16'd15);
        run_events(75);
        wait_results_done();

        // Sender pauses mid-phase until everything has come back.
        program_timer(pick_len(), pick_len(), pick_len(), pick_set_size());
        run_events(40);
        wait_results_done();
        run_events(40);
        wait_results_done();

        // Receiver holds off for a long stretch while events keep coming.
        program_timer(pick_len(), pick_len(), pick_len(), pick_set_size());
        long_hold_req = 1'b1;
        run_events(75);
        wait_results_done();

        // Maximum work length: work only ends by skip or restart.
        program_timer(16'hFFFF, 16'd1, 16'd1, 16'd2);
        run_events(70);
        wait_results_done();

        // Last part: no idling on either side.
        program_timer(pick_len(), pick_len(), pick_len(), pick_set_size());
        quiet = 1'b1;
        run_events(75);
        wait_results_done();

        repeat (8) @(posedge aclk);
        if (sb.error_count == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/wbpt_pkg.sv
src/wbpt_step.sv
src/work_break_phase_timer_top.sv
src/wbpt_checker.sv
tb/sv/work_break_phase_timer_top_tb.sv
